/* rtl/hsfd_pkg.sv */
// Shared types, codes and arithmetic helpers of the humidity sensor frame decoder.
package hsfd_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_word_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [15:0]        device_ident;
        logic [1:0]         status;
    } out_word_t;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FIRST_CRC  = 2'd1;
    localparam logic [1:0] STATUS_SECOND_CRC = 2'd2;

    localparam logic       KIND_MEASURE = 1'b0;
    localparam logic       KIND_IDENT   = 1'b1;

    localparam logic [0:0] REG_FRAME_KIND = 1'b0;

    localparam logic [2:0] POS_FIRST_MSB  = 3'd0;
    localparam logic [2:0] POS_FIRST_LSB  = 3'd1;
    localparam logic [2:0] POS_FIRST_CRC  = 3'd2;
    localparam logic [2:0] POS_SECOND_MSB = 3'd3;
    localparam logic [2:0] POS_SECOND_LSB = 3'd4;
    localparam logic [2:0] POS_SECOND_CRC = 3'd5;

    localparam logic [7:0]  CRC_POLY  = 8'h31;
    localparam logic [7:0]  CRC_INIT  = 8'hFF;
    localparam logic [14:0] TEMP_SPAN = 15'd17500;
    localparam logic [13:0] HUM_SPAN  = 14'd10000;
    localparam logic signed [15:0] TEMP_OFFSET = -16'sd4500;
    localparam logic [16:0] FULL_SCALE = 17'd65535;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    // Quotient by 65535 of a product below 2^31: the remainder estimate stays
    // below twice the divisor, so one compare corrects it.
    function automatic logic [14:0] div_full_scale(input logic [30:0] n);
        logic [14:0] q0;
        logic [16:0] r;
        q0 = n[30:16];
        r  = {1'b0, n[15:0]} + {2'b00, q0};
        return (r >= FULL_SCALE) ? q0 + 15'd1 : q0;
    endfunction

endpackage

/* rtl/humidity_sensor_frame_decoder_top.sv */
// Top level of the humidity sensor frame decoder: frame tracking, CRC check and conversion.
//
//   Channel   Signals                                  Direction
//   byte      byte_valid, byte_ready, byte_word        in, one received byte per word
//   result    result_valid, result_ready, result_word  out, one word per completed frame
//   config    psel, penable, pwrite, paddr, pwdata     APB write/read of frame_kind
//
// One byte word is accepted every cycle while byte_ready is high; the CRC and frame state update at acceptance.
// A result word follows the frame's last byte through registered stages: one stage holds the
// checked words, the next holds the converted result after the scaling multipliers.
// Reset clears the frame position and both pipeline valids; the CRC is 0xFF, frame_kind is 0.
// A stalled result stage holds its word; byte_ready drops only when both stages are full.
module humidity_sensor_frame_decoder_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  hsfd_pkg::in_word_t  byte_word,
    output logic                result_valid,
    input  logic                result_ready,
    output hsfd_pkg::out_word_t result_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import hsfd_pkg::*;

    logic        frame_kind_reg;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] second_reg, second_next;
    logic        fail_reg, fail_next;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [15:0] s1_first_reg, s1_first_next;
    logic [15:0] s1_second_reg, s1_second_next;
    logic [1:0]  s1_status_reg, s1_status_next;
    logic        s1_kind_reg, s1_kind_next;

    logic        out_valid_reg;
    out_word_t   out_word_reg, out_word_next;

    logic        accept;
    logic        emit;
    logic        out_free;
    logic        s1_move;
    logic [2:0]  pos_eff;
    logic        second_bad;
    logic [30:0] temp_prod;
    logic [29:0] hum_prod;
    logic [14:0] temp_raw;
    logic [14:0] hum_raw;
    logic [15:0] temp_sum;

    assign pready   = 1'b1;
    assign out_free = !out_valid_reg || result_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign byte_ready = !s1_valid_reg || out_free;
    assign accept   = byte_valid && byte_ready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_FRAME_KIND)
        begin
            prdata = {31'd0, frame_kind_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_kind_reg <= KIND_MEASURE;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_KIND)
        begin
            frame_kind_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        pos_eff = pos_reg;
        if (byte_word.frame_start || pos_reg > POS_SECOND_CRC
            || (frame_kind_reg == KIND_IDENT && pos_reg > POS_FIRST_CRC))
        begin
            pos_eff = POS_FIRST_MSB;
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        fail_next      = fail_reg;
        emit           = 1'b0;
        second_bad     = (crc_reg != byte_word.rx_byte);
        s1_first_next  = first_reg;
        s1_second_next = second_reg;
        s1_status_next = STATUS_OK;
        s1_kind_next   = frame_kind_reg;
        case (pos_eff)
            POS_FIRST_MSB:
            begin
                crc_next   = crc8_update(CRC_INIT, byte_word.rx_byte);
                first_next = {byte_word.rx_byte, 8'h00};
                pos_next   = POS_FIRST_LSB;
            end
            POS_FIRST_LSB:
            begin
                crc_next   = crc8_update(crc_reg, byte_word.rx_byte);
                first_next = first_reg | {8'h00, byte_word.rx_byte};
                pos_next   = POS_FIRST_CRC;
            end
            POS_FIRST_CRC:
            begin
                fail_next = (crc_reg != byte_word.rx_byte);
                crc_next  = CRC_INIT;
                if (frame_kind_reg == KIND_IDENT)
                begin
                    pos_next       = POS_FIRST_MSB;
                    emit           = 1'b1;
                    s1_status_next = fail_next ? STATUS_FIRST_CRC : STATUS_OK;
                end
                else
                begin
                    pos_next = POS_SECOND_MSB;
                end
            end
            POS_SECOND_MSB:
            begin
                crc_next    = crc8_update(CRC_INIT, byte_word.rx_byte);
                second_next = {byte_word.rx_byte, 8'h00};
                pos_next    = POS_SECOND_LSB;
            end
            POS_SECOND_LSB:
            begin
                crc_next    = crc8_update(crc_reg, byte_word.rx_byte);
                second_next = second_reg | {8'h00, byte_word.rx_byte};
                pos_next    = POS_SECOND_CRC;
            end
            default:
            begin
                crc_next     = CRC_INIT;
                pos_next     = POS_FIRST_MSB;
                emit         = 1'b1;
                s1_kind_next = KIND_MEASURE;
                if (fail_reg)
                begin
                    s1_status_next = STATUS_FIRST_CRC;
                end
                else if (second_bad)
                begin
                    s1_status_next = STATUS_SECOND_CRC;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_FIRST_MSB;
            crc_reg    <= CRC_INIT;
            first_reg  <= '0;
            second_reg <= '0;
            fail_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            fail_reg   <= fail_next;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = emit;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            s1_first_reg  <= s1_first_next;
            s1_second_reg <= s1_second_next;
            s1_status_reg <= s1_status_next;
            s1_kind_reg   <= s1_kind_next;
        end
    end

    always_comb
    begin
        temp_prod = {15'd0, s1_first_reg} * {16'd0, TEMP_SPAN};
        hum_prod  = {14'd0, s1_second_reg} * {16'd0, HUM_SPAN};
        temp_raw  = div_full_scale(temp_prod);
        hum_raw   = div_full_scale({1'b0, hum_prod});
        temp_sum  = $signed({1'b0, temp_raw}) + TEMP_OFFSET;

        out_word_next        = '0;
        out_word_next.status = s1_status_reg;
        if (s1_status_reg == STATUS_OK)
        begin
            if (s1_kind_reg == KIND_IDENT)
            begin
                out_word_next.device_ident = s1_first_reg;
            end
            else
            begin
                out_word_next.temperature_centi = temp_sum[14:0];
                out_word_next.humidity_centi    = hum_raw[13:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule

/* rtl/hsfd_checker.sv */
// Port-level checker for the humidity sensor frame decoder, bound to its top level.
module hsfd_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                byte_valid,
    input logic                byte_ready,
    input logic                result_valid,
    input logic                result_ready,
    input hsfd_pkg::out_word_t result_word
);
    import hsfd_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_word))
        else $error("Stalled result word changed or dropped.");

    a_error_clears_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.status != STATUS_OK
        |-> result_word.temperature_centi == 15'sd0 && result_word.humidity_centi == 14'd0
            && result_word.device_ident == 16'd0)
        else $error("Result with CRC error carries data.");

    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_word.humidity_centi <= 14'd10000
            && result_word.temperature_centi >= -15'sd4500
            && result_word.temperature_centi <= 15'sd13000)
        else $error("Converted value out of range.");

    a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(byte_valid && byte_ready, 2))
        else $error("Result word appeared without a byte accepted two cycles before.");

endmodule

bind humidity_sensor_frame_decoder_top hsfd_checker u_hsfd_checker (.*);
